/* src/bldq_pkg.sv */
// Shared types and codes for the bounded list deque.
package bldq_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_REAR  = 3'd1,
		MODE_INSERT_AT  = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_POP_REAR   = 3'd4,
		MODE_REMOVE_AT  = 3'd5,
		MODE_FIND       = 3'd6
	} bldq_mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_RANGE     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} bldq_status_t;

	// Per-cell update command; at most one flag is set in a cycle.
	typedef struct packed {
		logic load;
		logic from_left;
		logic from_right;
	} bldq_cell_ctl_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_SCAN = 2'b10
	} bldq_fsm_t;

endpackage

/* src/bounded_list_deque_unit.sv */
// Top level of the bounded list deque: a row of word cells with command decode and find scan.
//
// Usage: drive mode, position and value_in with start high; the item is taken at a
// rising edge where start is high and busy is low. Every item gives exactly one
// result, shown on value_out, found_index, status and entry_count for one cycle
// while done is high. The receiver cannot hold results off, so the block never
// waits on it.
//
// Push, insert, pop and remove act on all cells at once (each cell loads, takes
// its left neighbor's word, or its right neighbor's word in the same edge), so
// their result is registered and shown in the cycle after acceptance, and a new
// item may start in the next cycle. Find compares every cell against the key in the
// accept cycle and then walks the registered match bits one index a cycle, stopping
// at the first match or at the last live word; on an empty list it gives its result
// as the other commands do. Busy is high during that walk.
//
// Reset: arst_n clears the word count, the controller and the result strobe at
// once. Cell contents are not cleared; only words below the count are ever read.
module bounded_list_deque_unit import bldq_pkg::*; #(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  position,
	input  logic [31:0] value_in,
	output logic        done,
	output logic [31:0] value_out,
	output logic [3:0]  found_index,
	output logic [2:0]  status,
	output logic [4:0]  entry_count
);

	// Count needs to hold CAPACITY itself; cell indexes only reach CAPACITY-1.
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	// Width used when comparing the 4-bit position against counts and indexes.
	localparam int CMPW = (CW > 4) ? CW : 4;
	// Width used to hand the count to the 5-bit result field.
	localparam int XW   = (CW > 5) ? CW : 5;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	bldq_fsm_t            fsm_q;
	bldq_fsm_t            fsm_d;
	logic [IW-1:0]        scan_q;
	logic [IW-1:0]        scan_d;
	logic [CAPACITY-1:0]  match_q;

	logic [WORD_BITS-1:0] word_in;
	logic [WORD_BITS-1:0] cell_word  [CAPACITY];
	logic [CAPACITY-1:0]  cell_match;
	bldq_cell_ctl_t       cell_ctl   [CAPACITY];

	logic                 accept;
	logic                 do_insert;
	logic                 do_remove;
	logic                 load_match;
	logic [CMPW-1:0]      ins_k;
	logic [CMPW-1:0]      rem_k;
	logic [CMPW-1:0]      pos_ext;
	logic [CMPW-1:0]      cnt_ext;
	logic [WORD_BITS-1:0] removed_word;
	logic [31:0]          removed_out;

	logic                 emit;
	logic [31:0]          res_value;
	logic [IW-1:0]        res_index;
	bldq_status_t         res_status;

	logic [31:0]          value_out_q;
	logic [IW-1:0]        index_q;
	logic [2:0]           status_q;
	logic                 done_q;
	logic [CMPW-1:0]      index_ext;
	logic [XW-1:0]        count_ext;

	assign accept  = start && (fsm_q == FSM_IDLE);
	assign busy    = (fsm_q == FSM_SCAN);
	assign pos_ext = CMPW'(position);
	assign cnt_ext = CMPW'(count_q);

	// Stored words keep the low WORD_BITS bits of the input; results sign-extend
	// them back to the 32-bit field.
	generate
		if (WORD_BITS >= 32) begin : g_wide
			assign word_in     = WORD_BITS'(value_in);
			assign removed_out = removed_word[31:0];
		end else begin : g_narrow
			assign word_in     = value_in[WORD_BITS-1:0];
			assign removed_out = {{(32 - WORD_BITS){removed_word[WORD_BITS-1]}}, removed_word};
		end
	endgenerate

	// The word leaving the list on pop or remove.
	assign removed_word = cell_word[rem_k[IW-1:0]];

	// Command decode and find scan.
	always_comb begin
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		load_match = 1'b0;
		ins_k      = '0;
		rem_k      = '0;
		count_d    = count_q;
		fsm_d      = fsm_q;
		scan_d     = scan_q;
		emit       = 1'b0;
		res_value  = '0;
		res_index  = '0;
		res_status = STAT_OK;

		if (fsm_q == FSM_SCAN) begin
			if (match_q[scan_q]) begin
				emit      = 1'b1;
				res_index = scan_q;
				fsm_d     = FSM_IDLE;
			end else if (CW'(scan_q) == count_q - CW'(1)) begin
				emit       = 1'b1;
				res_status = STAT_NOT_FOUND;
				fsm_d      = FSM_IDLE;
			end else begin
				scan_d = scan_q + IW'(1);
			end
		end else if (accept) begin
			emit = 1'b1;
			unique case (mode)
				MODE_PUSH_FRONT, MODE_PUSH_REAR, MODE_INSERT_AT: begin
					if (count_q == CW'(CAPACITY)) begin
						res_status = STAT_FULL;
					end else begin
						do_insert = 1'b1;
						count_d   = count_q + CW'(1);
						priority if (mode == MODE_PUSH_FRONT ||
						             (mode == MODE_INSERT_AT && position == 4'd0)) begin
							ins_k = '0;
						end else if (mode == MODE_PUSH_REAR || pos_ext >= cnt_ext) begin
							ins_k = cnt_ext;
						end else begin
							ins_k = pos_ext;
						end
					end
				end
				MODE_POP_FRONT, MODE_POP_REAR: begin
					if (count_q == '0) begin
						res_status = STAT_EMPTY;
					end else begin
						do_remove = 1'b1;
						count_d   = count_q - CW'(1);
						rem_k     = (mode == MODE_POP_FRONT) ? '0 : cnt_ext - CMPW'(1);
						res_value = removed_out;
					end
				end
				MODE_REMOVE_AT: begin
					if (count_q == '0) begin
						res_status = STAT_EMPTY;
					end else if (pos_ext >= cnt_ext) begin
						res_status = STAT_RANGE;
					end else begin
						do_remove = 1'b1;
						count_d   = count_q - CW'(1);
						rem_k     = pos_ext;
						res_value = removed_out;
					end
				end
				MODE_FIND: begin
					if (count_q == '0) begin
						res_status = STAT_NOT_FOUND;
					end else begin
						// The result comes from the scan instead.
						emit       = 1'b0;
						load_match = 1'b1;
						scan_d     = '0;
						fsm_d      = FSM_SCAN;
					end
				end
				default: begin
					// Unused mode: no operation, plain ok result.
				end
			endcase
		end
	end

	// The row of cells. Insert: the cell at the insertion index loads the new word
	// and every cell above it, up to the first free one, takes its left neighbor. Remove:
	// every cell from the removal index up to the second to last takes its right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		assign cell_ctl[i].load       = do_insert && (CMPW'(i) == ins_k);
		assign cell_ctl[i].from_left  = do_insert && (CMPW'(i) > ins_k) && (CMPW'(i) <= cnt_ext);
		assign cell_ctl[i].from_right = do_remove && (CMPW'(i) >= rem_k) &&
		                                (CMPW'(i + 1) < cnt_ext);

		bldq_cell #(
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.load_word  (word_in),
			.left_word  (left_w),
			.right_word (right_w),
			.key        (word_in),
			.word       (cell_word[i]),
			.match      (cell_match[i])
		);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fsm_q   <= FSM_IDLE;
			scan_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			fsm_q   <= fsm_d;
			scan_q  <= scan_d;
			done_q  <= emit;
		end
	end

	// Match bits above the count are masked so the scan sees only live words.
	for (genvar j = 0; j < CAPACITY; j++) begin : g_match
		always_ff @(posedge clk) begin
			if (load_match) begin
				match_q[j] <= cell_match[j] && (CMPW'(j) < cnt_ext);
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (emit) begin
			value_out_q <= res_value;
			index_q     <= res_index;
			status_q    <= res_status;
		end
	end

	assign index_ext   = CMPW'(index_q);
	assign count_ext   = XW'(count_q);
	assign done        = done_q;
	assign value_out   = value_out_q;
	assign found_index = index_ext[3:0];
	assign status      = status_q;
	assign entry_count = count_ext[4:0];

endmodule

/* src/bldq_cell.sv */
// One storage cell of the list: holds a word, shifts from a neighbor and compares to a key.
module bldq_cell import bldq_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  bldq_cell_ctl_t       ctl,
	input  logic [WORD_BITS-1:0] load_word,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	input  logic [WORD_BITS-1:0] key,
	output logic [WORD_BITS-1:0] word,
	output logic                 match
);

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.from_left) begin
			word_q <= left_word;
		end else if (ctl.from_right) begin
			word_q <= right_word;
		end
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

/* dv/bldq_result_checker.sv */
// Result checker for the bounded list deque: shadow list, expected results and comparison.
module bldq_result_checker import bldq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  position,
	input  logic [31:0] value_in,
	input  logic        done,
	input  logic [31:0] value_out,
	input  logic [3:0]  found_index,
	input  logic [2:0]  status,
	input  logic [4:0]  entry_count,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0]  value;
		logic [3:0]   index;
		bldq_status_t stat;
		logic [4:0]   count;
	} list_result_t;

	logic [31:0]  shadow_words [CAPACITY];
	int           shadow_len;
	list_result_t pending_results [$];

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// Applies one operation to the shadow list and returns the result it should give.
	function automatic list_result_t apply_list_op(input logic [2:0] op, input logic [3:0] pos,
			input logic [31:0] word);
		list_result_t res;
		int           slot;
		bit           hit;
		res = '{value: '0, index: '0, stat: STAT_OK, count: '0};
		hit = 1'b0;
		case (bldq_mode_t'(op))
			MODE_PUSH_FRONT, MODE_PUSH_REAR, MODE_INSERT_AT: begin
				if (shadow_len >= CAPACITY) begin
					res.stat = STAT_FULL;
				end else begin
					if (op == MODE_PUSH_FRONT)
						slot = 0;
					else if (op == MODE_PUSH_REAR || int'(pos) >= shadow_len)
						slot = shadow_len;
					else
						slot = int'(pos);
					for (int i = shadow_len; i > slot; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[slot] = word;
					shadow_len++;
				end
			end
			MODE_POP_FRONT, MODE_POP_REAR, MODE_REMOVE_AT: begin
				if (shadow_len == 0) begin
					res.stat = STAT_EMPTY;
				end else if (op == MODE_REMOVE_AT && int'(pos) >= shadow_len) begin
					res.stat = STAT_RANGE;
				end else begin
					if (op == MODE_POP_FRONT)
						slot = 0;
					else if (op == MODE_POP_REAR)
						slot = shadow_len - 1;
					else
						slot = int'(pos);
					res.value = shadow_words[slot];
					for (int i = slot; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
				end
			end
			MODE_FIND: begin
				res.stat = STAT_NOT_FOUND;
				for (int i = 0; i < shadow_len; i++) begin
					if (!hit && shadow_words[i] == word) begin
						hit = 1'b1;
						res.index = i[3:0];
						res.stat = STAT_OK;
					end
				end
			end
			default: ;
		endcase
		res.count = shadow_len[4:0];
		return res;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		list_result_t want;
		if (!arst_n) begin
			shadow_len = 0;
			pending_results.delete();
		end else begin
			// A result always trails its item, so it is matched before the item accepted
			// at this same edge is predicted.
			if (done) begin
				if (pending_results.size() == 0) begin
					note_failure($sformatf("%0t: unexpected result value=%h idx=%0d st=%0d cnt=%0d",
						$realtime, value_out, found_index, status, entry_count));
				end else begin
					want = pending_results.pop_front();
					if (value_out !== want.value || found_index !== want.index ||
							status !== want.stat || entry_count !== want.count)
						note_failure($sformatf({"%0t: result mismatch: expected value=%h idx=%0d ",
							"st=%0d cnt=%0d, got value=%h idx=%0d st=%0d cnt=%0d"}, $realtime,
							want.value, want.index, want.stat, want.count,
							value_out, found_index, status, entry_count));
				end
			end
			if (start && !busy)
				pending_results.push_back(apply_list_op(mode, position, value_in));
		end
		pending = pending_results.size();
	end

endmodule

/* dv/tb_bounded_list_deque_unit.sv */
// Testbench top for the bounded list deque: clock, reset, stimulus and the final verdict.
module tb_bounded_list_deque_unit;
	import bldq_pkg::*;

	// The random part stops once this many items have been accepted in total.
	localparam int ITEM_TARGET = 1250;

	// Round styles steer the list length: growing rounds fill the list until pushes
	// are refused, shrinking rounds drain it until pops hit the empty case.
	localparam int ROUND_GROW    = 0;
	localparam int ROUND_SHRINK  = 1;
	localparam int ROUND_BALANCE = 2;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [3:0]  position;
	logic [31:0] value_in;
	logic        done;
	logic [31:0] value_out;
	logic [3:0]  found_index;
	logic [2:0]  status;
	logic [4:0]  entry_count;
	int          fail_count;
	int          pending;
	int          items_sent;

	bounded_list_deque_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.position    (position),
		.value_in    (value_in),
		.done        (done),
		.value_out   (value_out),
		.found_index (found_index),
		.status      (status),
		.entry_count (entry_count)
	);

	// The checker sees the same pins as the block and keeps its own copy of the list.
	bldq_result_checker result_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.position    (position),
		.value_in    (value_in),
		.done        (done),
		.value_out   (value_out),
		.found_index (found_index),
		.status      (status),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Safety net: even the slowest correct run (every item a full-length find plus
	// idle gaps) finishes far inside this bound.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// A small pool of words, extremes among them, so that finds often hit and
	// duplicate entries show that find reports the first match.
	function automatic logic [31:0] pool_word(input int k);
		case (k)
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5: return 32'h0000_002A;
			6: return 32'hFFFF_FFD6;
			default: return 32'h5A5A_A5A5;
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		if ($urandom_range(99) < 45)
			return pool_word($urandom_range(7));
		return $urandom;
	endfunction

	// Chooses an operation with weights that depend on the style of the round.
	function automatic bldq_mode_t pick_op(input int style);
		int r;
		r = $urandom_range(99);
		case (style)
			ROUND_GROW: begin
				if (r < 25) return MODE_PUSH_FRONT;
				if (r < 48) return MODE_PUSH_REAR;
				if (r < 70) return MODE_INSERT_AT;
				if (r < 75) return MODE_POP_FRONT;
				if (r < 80) return MODE_POP_REAR;
				if (r < 85) return MODE_REMOVE_AT;
				return MODE_FIND;
			end
			ROUND_SHRINK: begin
				if (r < 5)  return MODE_PUSH_FRONT;
				if (r < 10) return MODE_PUSH_REAR;
				if (r < 15) return MODE_INSERT_AT;
				if (r < 35) return MODE_POP_FRONT;
				if (r < 55) return MODE_POP_REAR;
				if (r < 80) return MODE_REMOVE_AT;
				return MODE_FIND;
			end
			default: begin
				if (r < 14) return MODE_PUSH_FRONT;
				if (r < 28) return MODE_PUSH_REAR;
				if (r < 44) return MODE_INSERT_AT;
				if (r < 56) return MODE_POP_FRONT;
				if (r < 68) return MODE_POP_REAR;
				if (r < 82) return MODE_REMOVE_AT;
				return MODE_FIND;
			end
		endcase
	endfunction

	// Presents one item at the falling edge and holds it until a rising edge finds
	// the block not busy. The next item or idle cycle follows at the next falling
	// edge, so start is written only once per step.
	task automatic send_item(input bldq_mode_t op, input logic [3:0] pos,
			input logic [31:0] word);
		@(negedge clk);
		start    <= 1'b1;
		mode     <= op;
		position <= pos;
		value_in <= word;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Idle cycles with start low; the payload pins carry noise that must be ignored.
	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start    <= 1'b0;
			mode     <= 3'($urandom_range(6));
			position <= 4'($urandom);
			value_in <= $urandom;
		end
	endtask

	// Stops sending until every result that is owed has come back.
	task automatic drain_results();
		idle_cycles(1);
		wait (pending == 0);
	endtask

	// The sender idles about 31 times in a hundred, except in one long stretch
	// in the middle of the random part where items go back to back.
	task automatic maybe_idle();
		if ((items_sent < 500 || items_sent >= 750) && $urandom_range(99) < 31)
			idle_cycles($urandom_range(1, 3));
	endtask

	initial begin
		int style;
		int round_len;
		bldq_mode_t op;
		logic [31:0] word;

		items_sent = 0;
		start      = 1'b0;
		mode       = MODE_FIND;
		position   = '0;
		value_in   = '0;
		arst_n     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Everything that an empty list must refuse.
		send_item(MODE_FIND,      4'd0,  32'h0000_0000);
		send_item(MODE_POP_FRONT, 4'd0,  32'h0000_0000);
		send_item(MODE_POP_REAR,  4'd0,  32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd0,  32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd15, 32'h0000_0000);

		// Build the list -1, max, middle word, min, 0, 1 through every way of adding:
		// insert at zero goes to the front, insert at or past the count to the rear.
		send_item(MODE_PUSH_FRONT, 4'd0,  32'h7FFF_FFFF);
		send_item(MODE_PUSH_REAR,  4'd0,  32'h8000_0000);
		send_item(MODE_INSERT_AT,  4'd0,  32'hFFFF_FFFF);
		send_item(MODE_INSERT_AT,  4'd15, 32'h0000_0000);
		send_item(MODE_INSERT_AT,  4'd4,  32'h0000_0001);
		send_item(MODE_INSERT_AT,  4'd2,  32'h5A5A_5A5A);

		// Finds at the front, in the middle, at the rear and without a match.
		send_item(MODE_FIND, 4'd0, 32'h8000_0000);
		send_item(MODE_FIND, 4'd0, 32'hFFFF_FFFF);
		send_item(MODE_FIND, 4'd0, 32'h0000_0001);
		send_item(MODE_FIND, 4'd0, 32'h0001_2345);

		// Removal past the end and at the count leaves the list alone.
		send_item(MODE_REMOVE_AT, 4'd15, 32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd6,  32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd5,  32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd1,  32'h0000_0000);
		send_item(MODE_REMOVE_AT, 4'd0,  32'h0000_0000);
		send_item(MODE_POP_FRONT, 4'd0,  32'h0000_0000);
		send_item(MODE_POP_REAR,  4'd0,  32'h0000_0000);
		send_item(MODE_PUSH_FRONT, 4'd0, 32'hA5A5_A5A5);
		send_item(MODE_POP_REAR,  4'd0,  32'h0000_0000);

		drain_results();

		// Random rounds. Growing rounds run the list into the full refusal, shrinking
		// rounds into the empty errors, and finds land at every depth in between.
		while (items_sent < ITEM_TARGET) begin
			// Balanced rounds are the last style.
			style = $urandom_range(ROUND_BALANCE);
			round_len = $urandom_range(20, 60);
			repeat (round_len) begin
				op = pick_op(style);
				word = pick_word();
				maybe_idle();
				send_item(op, 4'($urandom), word);
			end
			if ($urandom_range(3) == 0)
				drain_results();
		end

		// Wait for the last results, then long enough to catch a stray strobe.
		idle_cycles(1);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
